// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers clocked on clk with arst_n as disable
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define H2SST_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define H2SST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hw/rtl/h2sst_pkg.sv
// ----------------------------------------------------------------------------
// h2sst_pkg
// types, codes and sizes shared by the stream state table modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package h2sst_pkg;

	localparam int TABLE_ENTRIES = 128;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int ID_W = 31;
	localparam int CNT_W = 8;

	localparam logic [7:0] MAX_CONCURRENT_RST = 8'd100;

	localparam logic [2:0] FUNC_OPEN = 3'd0;
	localparam logic [2:0] FUNC_END_STREAM = 3'd1;
	localparam logic [2:0] FUNC_CLOSE = 3'd2;
	localparam logic [2:0] FUNC_REMOVE = 3'd3;
	localparam logic [2:0] FUNC_QUERY = 3'd4;
	localparam logic [2:0] FUNC_GC = 3'd5;

	localparam logic [2:0] STS_OK = 3'd0;
	localparam logic [2:0] STS_EVEN_ID = 3'd1;
	localparam logic [2:0] STS_NOT_INCR = 3'd2;
	localparam logic [2:0] STS_LIMIT = 3'd3;
	localparam logic [2:0] STS_FULL = 3'd4;
	localparam logic [2:0] STS_NOT_FOUND = 3'd5;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_OPEN = 3'd1;
	localparam logic [2:0] ST_HCR = 3'd2;
	localparam logic [2:0] ST_HCL = 3'd3;
	localparam logic [2:0] ST_CLOSED = 3'd4;

	typedef struct packed {
		logic [2:0]      func;
		logic [ID_W-1:0] strm_id;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [2:0]       stream_state;
		logic             is_active;
		logic [CNT_W-1:0] active_count;
		logic             can_create;
	} rsp_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [2:0]      state;
	} entry_t;

	typedef struct packed {
		logic start;
		logic rd;
		logic apply;
	} cmd_t;

	typedef struct packed {
		logic last_addr;
	} sts_t;

endpackage

// File: hw/rtl/h2sst_ctrl.sv
// ----------------------------------------------------------------------------
// h2sst_ctrl
// sequencer: accept, table sweep, drain, commit and result handoff
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module h2sst_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output h2sst_pkg::cmd_t   cmd,
	input  h2sst_pkg::sts_t   sts
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_APPLY = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nx;
	logic       rsp_valid_q;
	logic       out_free;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_nx = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.start = 1'b1;
					state_nx = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.rd = 1'b1;
				if (sts.last_addr) begin
					state_nx = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_nx = S_APPLY;
			end
			S_APPLY: begin
				if (out_free) begin
					cmd.apply = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.apply) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hw/rtl/h2sst_dpath.sv
// ----------------------------------------------------------------------------
// h2sst_dpath
// entry memory, valid bits, sweep trackers, counters and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module h2sst_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  h2sst_pkg::cmd_t   cmd,
	output h2sst_pkg::sts_t   sts,
	input  h2sst_pkg::req_t   req,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_data,
	output h2sst_pkg::rsp_t   rsp
);

	localparam int N = h2sst_pkg::TABLE_ENTRIES;
	localparam int IW = h2sst_pkg::IDX_W;
	localparam int CW = h2sst_pkg::CNT_W;
	localparam logic [7:0] MAX_CONC_RST = h2sst_pkg::MAX_CONCURRENT_RST;

	h2sst_pkg::entry_t mem [N];
	logic [N-1:0]      valid_q;

	h2sst_pkg::req_t   req_q;
	logic [7:0]        max_conc_q;
	logic [h2sst_pkg::ID_W-1:0] last_id_q;
	logic [CW-1:0]     active_q;

	logic [IW-1:0]     addr_q;
	logic              rd_s1;
	logic [IW-1:0]     idx_s1;
	h2sst_pkg::entry_t ent_s1;
	logic              ent_v_s1;

	logic              found_q;
	logic [IW-1:0]     found_idx_q;
	logic [2:0]        found_st_q;
	logic              free_q;
	logic [IW-1:0]     free_idx_q;

	logic              hit;
	logic              gc_clear;

	// commit decisions
	logic [2:0]        status_nx;
	logic [2:0]        state_nx;
	logic [CW-1:0]     active_nx;
	logic              mem_we;
	logic [IW-1:0]     mem_waddr;
	h2sst_pkg::entry_t mem_wdata;
	logic              v_set;
	logic              v_clr;
	logic              last_we;

	assign sts.last_addr = (addr_q == IW'(N - 1));
	assign hit = rd_s1 && ent_v_s1 && (ent_s1.id == req_q.strm_id);
	assign gc_clear = rd_s1 && ent_v_s1 && (req_q.func == h2sst_pkg::FUNC_GC)
		&& (ent_s1.state == h2sst_pkg::ST_CLOSED);

	// sweep read path, entry memory write and request capture
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			ent_s1 <= mem[addr_q];
			ent_v_s1 <= valid_q[addr_q];
			idx_s1 <= addr_q;
		end
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.start) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			rd_s1 <= 1'b0;
			found_q <= 1'b0;
			free_q <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd;
			if (cmd.start) begin
				addr_q <= '0;
				found_q <= 1'b0;
				free_q <= 1'b0;
			end else begin
				if (cmd.rd) begin
					addr_q <= addr_q + IW'(1);
				end
				if (hit && !found_q) begin
					found_q <= 1'b1;
				end
				if (rd_s1 && !ent_v_s1 && !free_q) begin
					free_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit && !found_q) begin
			found_idx_q <= idx_s1;
			found_st_q <= ent_s1.state;
		end
		if (rd_s1 && !ent_v_s1 && !free_q) begin
			free_idx_q <= idx_s1;
		end
	end

	always_comb begin
		status_nx = h2sst_pkg::STS_OK;
		state_nx = h2sst_pkg::ST_IDLE;
		active_nx = active_q;
		mem_we = 1'b0;
		mem_waddr = found_idx_q;
		mem_wdata = '{id: req_q.strm_id, state: h2sst_pkg::ST_OPEN};
		v_set = 1'b0;
		v_clr = 1'b0;
		last_we = 1'b0;
		unique case (req_q.func)
			h2sst_pkg::FUNC_OPEN: begin
				if (found_q) begin
					state_nx = found_st_q;
				end
				if (!req_q.strm_id[0]) begin
					status_nx = h2sst_pkg::STS_EVEN_ID;
				end else if (req_q.strm_id <= last_id_q) begin
					status_nx = h2sst_pkg::STS_NOT_INCR;
				end else if (active_q >= max_conc_q) begin
					status_nx = h2sst_pkg::STS_LIMIT;
				end else if (!found_q && !free_q) begin
					status_nx = h2sst_pkg::STS_FULL;
				end else begin
					mem_we = 1'b1;
					mem_waddr = found_q ? found_idx_q : free_idx_q;
					v_set = 1'b1;
					last_we = 1'b1;
					active_nx = active_q + CW'(1);
					state_nx = h2sst_pkg::ST_OPEN;
				end
			end
			h2sst_pkg::FUNC_END_STREAM: begin
				if (!found_q) begin
					status_nx = h2sst_pkg::STS_NOT_FOUND;
				end else begin
					state_nx = found_st_q;
					if (found_st_q == h2sst_pkg::ST_OPEN) begin
						state_nx = h2sst_pkg::ST_HCR;
						mem_we = 1'b1;
						mem_wdata.state = h2sst_pkg::ST_HCR;
					end
				end
			end
			h2sst_pkg::FUNC_CLOSE, h2sst_pkg::FUNC_REMOVE: begin
				if (!found_q) begin
					status_nx = h2sst_pkg::STS_NOT_FOUND;
				end else begin
					state_nx = (req_q.func == h2sst_pkg::FUNC_CLOSE) ?
						h2sst_pkg::ST_CLOSED : h2sst_pkg::ST_IDLE;
					v_clr = (req_q.func == h2sst_pkg::FUNC_REMOVE);
					if (found_st_q != h2sst_pkg::ST_CLOSED) begin
						mem_we = 1'b1;
						mem_wdata.state = h2sst_pkg::ST_CLOSED;
						if (active_q != '0) begin
							active_nx = active_q - CW'(1);
						end
					end
				end
			end
			h2sst_pkg::FUNC_QUERY: begin
				if (!found_q) begin
					status_nx = h2sst_pkg::STS_NOT_FOUND;
				end else begin
					state_nx = found_st_q;
				end
			end
			default: begin
				state_nx = h2sst_pkg::ST_IDLE;
			end
		endcase
		if (!cmd.apply) begin
			mem_we = 1'b0;
			v_set = 1'b0;
			v_clr = 1'b0;
			last_we = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			last_id_q <= '0;
			active_q <= '0;
			max_conc_q <= MAX_CONC_RST;
		end else begin
			if (gc_clear) begin
				valid_q[idx_s1] <= 1'b0;
			end
			if (v_set) begin
				valid_q[mem_waddr] <= 1'b1;
			end else if (v_clr) begin
				valid_q[mem_waddr] <= 1'b0;
			end
			if (last_we) begin
				last_id_q <= req_q.strm_id;
			end
			if (cmd.apply) begin
				active_q <= active_nx;
			end
			if (cfg_we) begin
				max_conc_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			rsp.status <= status_nx;
			rsp.stream_state <= state_nx;
			rsp.is_active <= (state_nx == h2sst_pkg::ST_OPEN)
				|| (state_nx == h2sst_pkg::ST_HCR) || (state_nx == h2sst_pkg::ST_HCL);
			rsp.active_count <= active_nx;
			rsp.can_create <= (active_nx < max_conc_q);
		end
	end

endmodule

// File: hw/rtl/http2_stream_state_table_unit.sv
// ----------------------------------------------------------------------------
// http2_stream_state_table_unit
// server-side http2 stream lifecycle table with a per-item sweep of all entries
// ----------------------------------------------------------------------------
// sequence: the sweep reads the entry memory one address per cycle, then drain and commit;
//   the result word is registered at commit, and no new request is taken until the commit,
//   since req_stall stays high outside the idle state
// reset: valid bits, counters and last client id clear at once, no clearing pass;
//   max_concurrent resets to 100
`timescale 1ns / 1ps
`include "assert_macros.svh"

module http2_stream_state_table_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  h2sst_pkg::req_t   req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output h2sst_pkg::rsp_t   rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_data
);

	h2sst_pkg::cmd_t cmd;
	h2sst_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	h2sst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	h2sst_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.req      (req),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.rsp      (rsp)
	);

	`H2SST_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
	`H2SST_ASSERT_NEXT(a_commit_gives_word, cmd.apply, rsp_valid)
	`H2SST_ASSERT_SAME(a_sweep_only_busy, cmd.rd || cmd.apply, req_stall && !cmd.start)

endmodule

// File: tb/http2_stream_state_table_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http2_stream_state_table_unit_tb
// drives open, end-stream, close, remove, query, gc and undefined words into the
// stream table, keeps its own copy of the table to predict every result word, and
// compares each accepted result field by field against the oldest prediction
// ----------------------------------------------------------------------------

module http2_stream_state_table_unit_tb;
	import h2sst_pkg::*;

	localparam int SWEEP_CYCLES = TABLE_ENTRIES + 3;
	localparam int WATCHDOG_LIMIT = 16 * SWEEP_CYCLES;
	localparam int REPORT_LIMIT = 10;
	localparam int PHASE_WORDS = 190;
	localparam logic [2:0] FUNC_UNDEF_A = 3'd6;
	localparam logic [2:0] FUNC_UNDEF_B = 3'd7;
	localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

	class stream_table_checker;
		bit              ent_valid [TABLE_ENTRIES];
		bit [ID_W-1:0]   ent_id [TABLE_ENTRIES];
		bit [2:0]        ent_state [TABLE_ENTRIES];
		bit [ID_W-1:0]   last_client;
		int unsigned     active;
		bit [7:0]        limit;
		rsp_t            pending_rsp [$];
		int              errors;

		function new();
			last_client = '0;
			active = 0;
			limit = MAX_CONCURRENT_RST;
			errors = 0;
		endfunction

		function void set_limit(logic [7:0] value);
			limit = value;
		endfunction

		function int outstanding();
			return pending_rsp.size();
		endfunction

		function int find_stream(bit [ID_W-1:0] id);
			for (int i = 0; i < TABLE_ENTRIES; i++)
				if (ent_valid[i] && ent_id[i] == id)
					return i;
			return -1;
		endfunction

		function int free_slot();
			for (int i = 0; i < TABLE_ENTRIES; i++)
				if (!ent_valid[i])
					return i;
			return -1;
		endfunction

		function void close_stream(int i);
			if (ent_state[i] != ST_CLOSED) begin
				ent_state[i] = ST_CLOSED;
				if (active > 0)
					active--;
			end
		endfunction

		function void note_request(req_t r);
			rsp_t want;
			int hit;
			int slot;
			bit [2:0] st;
			hit = find_stream(r.strm_id);
			st = ST_IDLE;
			want = '0;
			want.status = STS_OK;
			case (r.func)
			FUNC_OPEN: begin
				if (!r.strm_id[0])
					want.status = STS_EVEN_ID;
				else if (r.strm_id <= last_client)
					want.status = STS_NOT_INCR;
				else if (active >= limit)
					want.status = STS_LIMIT;
				else begin
					slot = (hit >= 0) ? hit : free_slot();
					if (slot < 0)
						want.status = STS_FULL;
					else begin
						last_client = r.strm_id;
						ent_valid[slot] = 1'b1;
						ent_id[slot] = r.strm_id;
						ent_state[slot] = ST_OPEN;
						active++;
						hit = slot;
					end
				end
				if (hit >= 0)
					st = ent_state[hit];
			end
			FUNC_END_STREAM, FUNC_CLOSE, FUNC_REMOVE, FUNC_QUERY: begin
				if (hit < 0)
					want.status = STS_NOT_FOUND;
				else begin
					case (r.func)
					FUNC_END_STREAM: begin
						if (ent_state[hit] == ST_OPEN)
							ent_state[hit] = ST_HCR;
					end
					FUNC_CLOSE: close_stream(hit);
					FUNC_REMOVE: begin
						close_stream(hit);
						ent_valid[hit] = 1'b0;
					end
					default: ;
					endcase
					st = ent_valid[hit] ? ent_state[hit] : ST_IDLE;
				end
			end
			FUNC_GC: begin
				for (int i = 0; i < TABLE_ENTRIES; i++)
					if (ent_valid[i] && ent_state[i] == ST_CLOSED)
						ent_valid[i] = 1'b0;
			end
			default: ;
			endcase
			want.stream_state = st;
			want.is_active = (st == ST_OPEN || st == ST_HCR || st == ST_HCL);
			want.active_count = CNT_W'(active);
			want.can_create = (active < limit);
			pending_rsp.insert(pending_rsp.size(), want);
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (pending_rsp.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("unexpected result word: status %0d state %0d count %0d",
						got.status, got.stream_state, got.active_count);
				return;
			end
			want = pending_rsp[0];
			pending_rsp.delete(0);
			if (got.status !== want.status || got.stream_state !== want.stream_state ||
					got.is_active !== want.is_active ||
					got.active_count !== want.active_count ||
					got.can_create !== want.can_create) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display({"mismatch (exp/got): status %0d/%0d state %0d/%0d ",
						"active %0d/%0d count %0d/%0d create %0d/%0d"},
						want.status, got.status, want.stream_state, got.stream_state,
						want.is_active, got.is_active, want.active_count,
						got.active_count, want.can_create, got.can_create);
			end
		endfunction
	endclass

	logic            clk;
	logic            arst_n = 1'b0;
	logic            req_valid = 1'b0;
	logic            req_stall;
	req_t            req = '0;
	logic            rsp_valid;
	logic            rsp_stall = 1'b0;
	rsp_t            rsp;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [7:0]      cfg_data = '0;
	bit              calm = 1'b0;
	logic [ID_W-1:0] next_open_id = ID_W'(1);
	logic [ID_W-1:0] opened_ids [$];
	logic [ID_W-1:0] fill_ids [$];
	int              counted = 0;
	int              idle_cycles;
	stream_table_checker sb;

	http2_stream_state_table_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_limit(cfg_data);
			if (req_valid && !req_stall)
				sb.note_request(req);
			if (rsp_valid && !rsp_stall)
				sb.check_response(rsp);
		end
		rsp_stall <= !calm && ($urandom_range(0, 99) < 26);
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[http2_stream_state_table_unit] ERROR");
		$finish;
	end

	task automatic send_word(input logic [2:0] op, input logic [ID_W-1:0] sid);
		while (!calm && $urandom_range(0, 99) < 26) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{func: op, strm_id: sid};
		do @(posedge clk); while (req_stall);
		if (op <= FUNC_GC)
			counted++;
	endtask

	// wait for every outstanding result word
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	task automatic write_limit(input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic open_next();
		if ($urandom_range(0, 19) == 0)
			next_open_id = next_open_id + ID_W'(2 * $urandom_range(1, 1 << 16));
		else
			next_open_id = next_open_id + ID_W'(2 * $urandom_range(1, 8));
		opened_ids.insert(opened_ids.size(), next_open_id);
		if (opened_ids.size() > 48)
			opened_ids.delete(0);
		send_word(FUNC_OPEN, next_open_id);
	endtask

	task automatic run_random(input int n);
		int pick;
		int stop;
		logic [31:0] rnd;
		stop = counted + n;
		while (counted < stop) begin
			pick = $urandom_range(0, 99);
			rnd = $urandom;
			if (pick < 30 || opened_ids.size() == 0)
				open_next();
			else if (pick < 80)
				send_word(3'($urandom_range(FUNC_END_STREAM, FUNC_QUERY)),
					opened_ids[$urandom_range(0, opened_ids.size() - 1)]);
			else if (pick < 84)
				send_word(FUNC_GC, rnd[ID_W-1:0]);
			else if (pick < 88)
				send_word(FUNC_OPEN, {rnd[ID_W-1:1], 1'b0});
			else if (pick < 92)
				send_word(FUNC_OPEN, ID_W'($urandom_range(0, next_open_id)));
			else if (pick < 97)
				send_word(3'($urandom_range(FUNC_END_STREAM, FUNC_QUERY)), rnd[ID_W-1:0]);
			else
				send_word(rnd[31] ? FUNC_UNDEF_A : FUNC_UNDEF_B, rnd[ID_W-1:0]);
		end
	endtask

	task automatic random_phase(input logic [7:0] value, input bit no_idle);
		drain();
		write_limit(value);
		calm = no_idle;
		run_random(PHASE_WORDS);
		calm = 1'b0;
	endtask

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// open rejections under the reset limit, with one accepted open
		send_word(FUNC_OPEN, '0);
		send_word(FUNC_OPEN, ID_W'(1));
		send_word(FUNC_OPEN, ID_W'(1));
		send_word(FUNC_OPEN, ID_W'(4));
		drain();
		write_limit(8'd2);
		send_word(FUNC_OPEN, ID_W'(3));
		send_word(FUNC_OPEN, ID_W'(5));
		send_word(FUNC_END_STREAM, ID_W'(3));
		send_word(FUNC_END_STREAM, ID_W'(3));
		send_word(FUNC_QUERY, ID_W'(3));
		send_word(FUNC_CLOSE, ID_W'(3));
		send_word(FUNC_CLOSE, ID_W'(3));
		send_word(FUNC_QUERY, ID_W'(7));
		send_word(FUNC_END_STREAM, ID_W'(9));
		send_word(FUNC_CLOSE, ID_W'(9));
		send_word(FUNC_REMOVE, ID_W'(9));
		send_word(FUNC_REMOVE, ID_W'(1));
		send_word(FUNC_GC, '0);
		send_word(FUNC_QUERY, ID_W'(3));
		send_word(FUNC_UNDEF_A, ID_MAX);
		send_word(FUNC_UNDEF_B, 31'h2AAA_AAAA);
		send_word(FUNC_QUERY, ID_MAX);
		send_word(FUNC_QUERY, '0);
		drain();
		write_limit(8'd0);
		send_word(FUNC_OPEN, ID_W'(11));
		send_word(FUNC_QUERY, ID_W'(11));
		next_open_id = ID_W'(11);

		// fill every entry: first up to the limit, then close every stream and collect them
		drain();
		write_limit(8'd128);
		repeat (TABLE_ENTRIES) begin
			open_next();
			fill_ids.insert(fill_ids.size(), next_open_id);
		end
		open_next();
		foreach (fill_ids[i])
			send_word(FUNC_CLOSE, fill_ids[i]);
		open_next();
		send_word(FUNC_GC, '0);
		send_word(FUNC_QUERY, fill_ids[0]);

		random_phase(8'd100, 1'b0);
		random_phase(8'd1, 1'b0);
		random_phase(8'd127, 1'b1);
		random_phase(8'd5, 1'b0);
		random_phase(8'd128, 1'b0);
		random_phase(8'd64, 1'b0);

		drain();
		send_word(FUNC_GC, '0);
		send_word(FUNC_OPEN, ID_MAX);
		send_word(FUNC_QUERY, ID_MAX);
		drain();
		repeat (SWEEP_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("[http2_stream_state_table_unit] OK");
		else
			$display("[http2_stream_state_table_unit] ERROR");
		$finish;
	end

endmodule
